// ===== src/chained_hash_map_16bit_key_defines.svh =====
// Assertion macros shared by the hash map modules.
`ifndef CHAINED_HASH_MAP_16BIT_KEY_DEFINES_SVH
`define CHAINED_HASH_MAP_16BIT_KEY_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CHM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CHM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/chm_pkg.sv =====
// Types and constants of the chained hash map.
package chm_pkg;

    // request codes
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // hash of up to five digits stays below 2^26
    localparam int HASH_W    = 26;
    // remainder: reciprocal quotient, registered, then multiply back and subtract
    localparam int MOD_STEPS = 2;
    localparam int MAX_DIGITS = 5;

    // x / 10 == (x * DIV10_MUL) >> DIV10_SHIFT for every 16-bit x
    localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
    localparam int          DIV10_SHIFT = 19;
    localparam logic [5:0]  ASCII_ZERO  = 6'd48;

    typedef struct packed {
        logic        req_type;
        logic [15:0] key;
        logic [15:0] value_handle;
    } t_in_word;

    typedef struct packed {
        logic        found;
        logic [15:0] value_out;
        logic [1:0]  status;
    } t_out_word;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIGIT,
        S_FOLD,
        S_MOD,
        S_HEAD,
        S_LINK,
        S_CMP,
        S_ACT,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr;
        logic load;
        logic digit;
        logic fold;
        logic mod_step;
        logic head_rd;
        logic at_head;
        logic at_node;
        logic follow;
        logic hit;
        logic miss;
        logic act;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic digit_last;
        logic fold_last;
        logic mod_last;
        logic link_null;
        logic key_match;
        logic out_free;
    } t_sts;

endpackage

// ===== src/chm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/chm_ctrl.sv =====
// Request sequencer of the hash map.
`include "chained_hash_map_16bit_key_defines.svh"

module chm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  chm_pkg::t_sts i_sts,
    output chm_pkg::t_cmd o_cmd
);

    chm_pkg::t_state r_state;
    chm_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chm_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            chm_pkg::S_CLEAR: if (i_sts.clr_last) n_state = chm_pkg::S_IDLE;
            chm_pkg::S_IDLE:  if (i_in_valid) n_state = chm_pkg::S_DIGIT;
            chm_pkg::S_DIGIT: if (i_sts.digit_last) n_state = chm_pkg::S_FOLD;
            chm_pkg::S_FOLD:  if (i_sts.fold_last) n_state = chm_pkg::S_MOD;
            chm_pkg::S_MOD:   if (i_sts.mod_last) n_state = chm_pkg::S_HEAD;
            chm_pkg::S_HEAD:  n_state = chm_pkg::S_LINK;
            chm_pkg::S_LINK: begin
                n_state = i_sts.link_null ? chm_pkg::S_ACT : chm_pkg::S_CMP;
            end
            chm_pkg::S_CMP: begin
                if (i_sts.key_match || i_sts.link_null) n_state = chm_pkg::S_ACT;
            end
            chm_pkg::S_ACT:   n_state = chm_pkg::S_OUT;
            chm_pkg::S_OUT:   if (i_sts.out_free) n_state = chm_pkg::S_IDLE;
            default:          n_state = chm_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            chm_pkg::S_CLEAR: o_cmd.clr = 1'b1;
            chm_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            chm_pkg::S_DIGIT: o_cmd.digit = 1'b1;
            chm_pkg::S_FOLD:  o_cmd.fold = 1'b1;
            chm_pkg::S_MOD:   o_cmd.mod_step = 1'b1;
            chm_pkg::S_HEAD:  o_cmd.head_rd = 1'b1;
            chm_pkg::S_LINK: begin
                o_cmd.at_head = 1'b1;
                o_cmd.follow  = !i_sts.link_null;
                o_cmd.miss    = i_sts.link_null;
            end
            chm_pkg::S_CMP: begin
                o_cmd.at_node = 1'b1;
                o_cmd.hit     = i_sts.key_match;
                o_cmd.miss    = !i_sts.key_match && i_sts.link_null;
                o_cmd.follow  = !i_sts.key_match && !i_sts.link_null;
            end
            chm_pkg::S_ACT: o_cmd.act = 1'b1;
            chm_pkg::S_OUT: o_cmd.emit = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

    `CHM_ASSERT_NXT(a_accept_starts_hash, i_in_valid && !o_in_stall, r_state == chm_pkg::S_DIGIT, "accepted word did not start hashing")
    `CHM_ASSERT_IMP(a_emit_needs_room, o_cmd.emit, i_sts.out_free, "result emitted into a full output register")
    `CHM_ASSERT_IMP(a_walk_single_outcome, o_cmd.at_node, $onehot({o_cmd.hit, o_cmd.miss, o_cmd.follow}), "chain walk took no or several outcomes")

endmodule

// ===== src/chm_dp.sv =====
// Hashing, chain walk, table storage and output register of the hash map.
`include "chained_hash_map_16bit_key_defines.svh"

module chm_dp #(
    parameter int BUCKET_COUNT = 128,
    parameter int NODE_POOL    = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  chm_pkg::t_in_word   i_in_word,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output chm_pkg::t_out_word  o_out_word,
    input  chm_pkg::t_cmd       i_cmd,
    output chm_pkg::t_sts       o_sts
);

    localparam int RW = $clog2(BUCKET_COUNT);
    localparam int NW = $clog2(NODE_POOL);
    localparam int LW = $clog2(NODE_POOL + 1);
    localparam int NODE_W = 32 + LW;
    localparam int HW = chm_pkg::HASH_W;
    localparam int MSW = $clog2(chm_pkg::MOD_STEPS);
    // floor(h / BUCKET_COUNT) == (h * MOD_MUL) >> MOD_SH for every HW-bit h
    localparam int MOD_SH = HW + RW;
    localparam longint unsigned MOD_MUL =
        ((64'd1 << MOD_SH) + 64'(BUCKET_COUNT) - 64'd1) / 64'(BUCKET_COUNT);

    chm_pkg::t_in_word  r_req;
    chm_pkg::t_out_word r_res;
    chm_pkg::t_out_word r_out;
    logic               r_out_valid;
    logic [15:0]        r_quot;
    logic [3:0]         r_dig [chm_pkg::MAX_DIGITS];
    logic [2:0]         r_ndig;
    logic [HW-1:0]      r_h;
    logic [HW-1:0]      r_mq;
    logic [RW-1:0]      r_rem;
    logic [MSW-1:0]     r_mcnt;
    logic [RW-1:0]      r_clr;
    logic [LW-1:0]      r_link;
    logic [LW-1:0]      r_head;
    logic [LW-1:0]      r_used;
    logic               r_found;
    logic [NODE_W-1:0]  r_node;

    logic [31:0]        prod;
    logic [15:0]        quot;
    logic [3:0]         digit;
    logic [HW:0]        mod_mul;
    logic [2*HW:0]      mod_prod;
    logic [HW-1:0]      mod_quot;
    logic [HW-1:0]      mod_rem;
    logic [LW-1:0]      head_rdata;
    logic [NODE_W-1:0]  node_rdata;
    logic [LW-1:0]      cur_link;
    logic [LW-1:0]      link_m1;
    logic [LW-1:0]      used_p1;
    logic               pool_full;
    logic               bk_we;
    logic [RW-1:0]      bk_waddr;
    logic [LW-1:0]      bk_wdata;
    logic               nd_we;
    logic [NW-1:0]      nd_waddr;
    logic [NODE_W-1:0]  nd_wdata;

    // one decimal digit by reciprocal multiply
    assign prod  = r_quot * chm_pkg::DIV10_MUL;
    assign quot  = 16'(prod >> chm_pkg::DIV10_SHIFT);
    assign digit = 4'(r_quot - ((quot << 3) + (quot << 1)));

    // bucket remainder: reciprocal quotient, then multiply back and subtract
    assign mod_mul  = (HW+1)'(MOD_MUL);
    assign mod_prod = r_h * mod_mul;
    assign mod_quot = HW'(mod_prod >> MOD_SH);
    assign mod_rem  = r_h - HW'(r_mq * HW'(BUCKET_COUNT));

    // current link of the chain walk
    assign cur_link  = i_cmd.at_head ? head_rdata : node_rdata[LW-1:0];
    assign link_m1   = cur_link - LW'(1);
    assign used_p1   = r_used + LW'(1);
    assign pool_full = (r_used == LW'(NODE_POOL));

    // hash pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_in_word;
            r_quot <= i_in_word.key;
            r_ndig <= '0;
            r_h    <= '0;
            r_rem  <= '0;
            r_mcnt <= '0;
        end
        if (i_cmd.digit) begin
            r_dig[r_ndig] <= digit;
            r_ndig        <= r_ndig + 3'd1;
            r_quot        <= quot;
        end
        if (i_cmd.fold) begin
            r_h    <= HW'({r_h, 5'b0} - {5'b0, r_h}
                      + HW'(chm_pkg::ASCII_ZERO + 6'(r_dig[r_ndig - 3'd1])));
            r_ndig <= r_ndig - 3'd1;
        end
        if (i_cmd.mod_step) begin
            if (r_mcnt == '0) begin
                r_mq <= mod_quot;
            end else begin
                r_rem <= mod_rem[RW-1:0];
            end
            r_mcnt <= r_mcnt + MSW'(1);
        end
    end

    // chain walk capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.at_head) r_head <= head_rdata;
        if (i_cmd.follow) r_link <= cur_link;
        if (i_cmd.hit) begin
            r_found <= 1'b1;
            r_node  <= node_rdata;
        end
        if (i_cmd.miss) r_found <= 1'b0;
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.act) begin
            if (r_req.req_type == chm_pkg::REQ_LOOKUP) begin
                r_res.found     <= r_found;
                r_res.value_out <= r_found ? r_node[LW +: 16] : 16'd0;
                r_res.status    <= r_found ? chm_pkg::ST_OK : chm_pkg::ST_MISS;
            end else if (!r_found && pool_full) begin
                r_res.found     <= 1'b0;
                r_res.value_out <= 16'd0;
                r_res.status    <= chm_pkg::ST_FULL;
            end else begin
                r_res.found     <= r_found;
                r_res.value_out <= r_req.value_handle;
                r_res.status    <= chm_pkg::ST_OK;
            end
        end
    end

    // pool fill count and clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_clr  <= '0;
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + RW'(1);
            if (i_cmd.act && r_req.req_type == chm_pkg::REQ_INSERT && !r_found
                && !pool_full) begin
                r_used <= used_p1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) r_out <= r_res;
    end

    function automatic logic [NW-1:0] link_m1_q();
        logic [LW-1:0] v;
        v = r_link - LW'(1);
        return v[NW-1:0];
    endfunction

    // table write ports
    always_comb begin
        bk_we    = 1'b0;
        bk_waddr = r_rem;
        bk_wdata = used_p1;
        nd_we    = 1'b0;
        nd_waddr = r_used[NW-1:0];
        nd_wdata = {r_req.key, r_req.value_handle, r_head};
        if (i_cmd.clr) begin
            bk_we    = 1'b1;
            bk_waddr = r_clr;
            bk_wdata = '0;
        end else if (i_cmd.act && r_req.req_type == chm_pkg::REQ_INSERT) begin
            if (r_found) begin
                nd_we    = 1'b1;
                nd_waddr = link_m1_q();
                nd_wdata = {r_req.key, r_req.value_handle, r_node[LW-1:0]};
            end else if (!pool_full) begin
                nd_we = 1'b1;
                bk_we = 1'b1;
            end
        end
    end

    chm_ram #(
        .WIDTH (LW),
        .DEPTH (BUCKET_COUNT)
    ) u_bucket_ram (
        .i_clk   (i_clk),
        .i_we    (bk_we),
        .i_waddr (bk_waddr),
        .i_wdata (bk_wdata),
        .i_re    (i_cmd.head_rd),
        .i_raddr (r_rem),
        .o_rdata (head_rdata)
    );

    chm_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_POOL)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (nd_we),
        .i_waddr (nd_waddr),
        .i_wdata (nd_wdata),
        .i_re    (i_cmd.follow),
        .i_raddr (link_m1[NW-1:0]),
        .o_rdata (node_rdata)
    );

    // status to the sequencer
    assign o_sts.clr_last   = (r_clr == RW'(BUCKET_COUNT - 1));
    assign o_sts.digit_last = (quot == 16'd0) || (r_ndig == 3'(chm_pkg::MAX_DIGITS - 1));
    assign o_sts.fold_last  = (r_ndig == 3'd1);
    assign o_sts.mod_last   = (r_mcnt == MSW'(chm_pkg::MOD_STEPS - 1));
    assign o_sts.link_null  = (cur_link == '0);
    assign o_sts.key_match  = (node_rdata[NODE_W-1 -: 16] == r_req.key);
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    `CHM_ASSERT_IMP(a_used_in_range, 1'b1, r_used <= LW'(NODE_POOL), "node count beyond pool size")
    `CHM_ASSERT_NXT(a_valid_only_on_emit, !r_out_valid && !i_cmd.emit, !r_out_valid, "output valid rose without a result")
    `CHM_ASSERT_IMP(a_no_write_while_clearing, i_cmd.clr, !nd_we, "node written during bucket clear")

endmodule

// ===== src/chained_hash_map_16bit_key.sv =====
// Top level of the chained hash map with 16-bit keys.
//
//   channel | direction | handshake              | word
//   in      | input     | i_in_valid / o_in_stall | chm_pkg::t_in_word
//   out     | output    | o_out_valid / i_out_stall | chm_pkg::t_out_word
//
// Between one acceptance and the next, a request passes through the digit unit over
// the decimal digits of the key (1 to 5), the remainder unit, and the node memory
// walk, which reads one node per cycle.
// After reset all BUCKET_COUNT bucket heads are cleared in turn; no word is
// taken meanwhile. One request is in flight at a time; a finished word waits in
// the output register while the next request is taken, and a request whose
// result finds that register still held waits as long as i_out_stall stays high.
module chained_hash_map_16bit_key #(
    parameter int BUCKET_COUNT = 128,
    parameter int NODE_POOL    = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  chm_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output chm_pkg::t_out_word o_out_word
);

    chm_pkg::t_cmd cmd;
    chm_pkg::t_sts sts;

    chm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    chm_dp #(
        .BUCKET_COUNT (BUCKET_COUNT),
        .NODE_POOL    (NODE_POOL)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
